[rtl/tgi_pkg.sv]
// Package for the tripod gait interpolator: configuration, command and result
// word types, register indexes and the key pose function. No dependencies.
package tgi_pkg;

    localparam int LEGS = 6;

    localparam logic [8:0] PROG_ONE = 9'd256;

    localparam logic [2:0] REG_FORWARD_STEP = 3'd0;
    localparam logic [2:0] REG_SIDE_STEP    = 3'd1;
    localparam logic [2:0] REG_BODY_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_LIFT_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_LEG_REACH    = 3'd4;
    localparam logic [2:0] REG_LEG_SPACING  = 3'd5;
    localparam logic [2:0] REG_FRONT_TILT   = 3'd6;
    localparam logic [2:0] REG_SIDE_TILT    = 3'd7;

    typedef logic [1:0] t_phase;

    typedef enum logic [1:0] {
        POSE_NEUTRAL,
        POSE_BACK,
        POSE_LIFT,
        POSE_FWD
    } t_pose_id;

    typedef struct packed {
        logic signed [8:0] forward_step;
        logic signed [8:0] side_step;
        logic [9:0]        body_height;
        logic [8:0]        lift_height;
        logic [9:0]        leg_reach;
        logic [9:0]        leg_spacing;
        logic signed [8:0] front_tilt;
        logic signed [8:0] side_tilt;
    } t_cfg;

    typedef struct packed {
        logic [8:0] prog;
        t_phase     phase;
    } t_cmd;

    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic signed [13:0] z;
    } t_xyz;

    typedef struct packed {
        logic [2:0]         leg;
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic signed [12:0] z;
        logic               last;
    } t_res;

    // emit order 0,2,4,1,3,5
    function automatic logic [2:0] leg_order(input logic [2:0] k);
        logic [2:0] leg;
        case (k)
            3'd0:    leg = 3'd0;
            3'd1:    leg = 3'd2;
            3'd2:    leg = 3'd4;
            3'd3:    leg = 3'd1;
            3'd4:    leg = 3'd3;
            default: leg = 3'd5;
        endcase
        return leg;
    endfunction

    function automatic t_xyz key_pose(input logic [2:0] leg, input t_pose_id pose,
                                      input t_cfg cfg, input logic [7:0] extra);
        logic               right;
        logic               middle;
        logic               back;
        logic signed [13:0] xb;
        logic signed [13:0] yo;
        logic signed [13:0] zb;
        logic signed [13:0] fs;
        logic signed [13:0] ss;
        logic signed [13:0] ft;
        logic signed [13:0] st;
        logic signed [13:0] lift;
        t_xyz               p;
        right  = (leg >= 3'd3);
        middle = (leg == 3'd1) || (leg == 3'd4);
        back   = (leg == 3'd0) || (leg == 3'd5);
        fs     = 14'(cfg.forward_step);
        ss     = 14'(cfg.side_step);
        ft     = 14'(cfg.front_tilt);
        st     = 14'(cfg.side_tilt);
        lift   = $signed({5'b0, cfg.lift_height});
        xb     = $signed({4'b0, cfg.leg_reach});
        if (middle) begin
            xb = xb + $signed({6'b0, extra});
        end
        if (middle) begin
            yo = '0;
        end else if (back) begin
            yo = -$signed({4'b0, cfg.leg_spacing});
        end else begin
            yo = $signed({4'b0, cfg.leg_spacing});
        end
        zb = -$signed({4'b0, cfg.body_height});
        if (!middle) begin
            zb = back ? (zb - ft) : (zb + ft);
        end
        zb = right ? (zb + st) : (zb - st);
        p.x = xb;
        p.y = yo;
        p.z = zb;
        case (pose)
            POSE_BACK: begin
                p.x = right ? (xb + ss) : (xb - ss);
                p.y = yo - fs;
            end
            POSE_LIFT: begin
                p.z = zb + lift;
            end
            POSE_FWD: begin
                p.x = right ? (xb - ss) : (xb + ss);
                p.y = yo + fs;
            end
            default: begin
            end
        endcase
        return p;
    endfunction

endpackage

[rtl/tgi_front.sv]
// Front end: clamps progress, tags each word with the gait phase, advances the
// phase on full progress and buffers commands in a short queue. Uses tgi_pkg.
module tgi_front import tgi_pkg::*; #(
    parameter int CMD_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [8:0] i_progress,
    output logic       o_full,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CW = $clog2(CMD_DEPTH + 1);

    t_cmd           r_mem [CMD_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    t_phase         r_phase;

    logic           accept;
    logic           pop;
    logic [8:0]     prog_c;

    assign o_full      = (r_cnt == CW'(CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign accept      = i_push && !o_full;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign prog_c      = (i_progress > PROG_ONE) ? PROG_ONE : i_progress;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wr] <= '{prog: prog_c, phase: r_phase};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_phase <= '0;
        end else begin
            if (accept) begin
                r_wr <= (r_wr == PW'(CMD_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                if (prog_c == PROG_ONE) begin
                    r_phase <= r_phase + 1'b1;
                end
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(CMD_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(accept) - CW'(pop);
        end
    end

endmodule

[rtl/tgi_back.sv]
// Back end: steps through the six legs of the head command, builds key poses,
// then multiplies and floors over a two stage pipeline. Uses tgi_pkg.
module tgi_back import tgi_pkg::*; #(
    parameter int RES_DEPTH       = 8,
    parameter int MID_REACH_EXTRA = 50
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_pop,
    output logic o_res_vld,
    output t_res o_res
);

    localparam int SW = $clog2(RES_DEPTH + 1);

    logic [2:0]         r_k;
    logic [SW-1:0]      r_slots;

    logic               r_s1_vld;
    logic [2:0]         r_s1_leg;
    logic               r_s1_last;
    logic [8:0]         r_s1_prog;
    t_xyz               r_s1_a;
    t_xyz               r_s1_d;

    logic               r_s2_vld;
    logic [2:0]         r_s2_leg;
    logic               r_s2_last;
    t_xyz               r_s2_a;
    logic signed [23:0] r_s2_px;
    logic signed [23:0] r_s2_py;
    logic signed [23:0] r_s2_pz;

    logic               issue;
    logic [2:0]         leg;
    t_phase             from;
    t_xyz               pa;
    t_xyz               pb;
    logic signed [9:0]  prog_s;
    logic signed [15:0] sum_x;
    logic signed [15:0] sum_y;
    logic signed [15:0] sum_z;

    assign issue     = i_cmd_valid && (r_slots < SW'(RES_DEPTH));
    assign o_cmd_pop = issue && (r_k == 3'(LEGS - 1));
    assign leg       = leg_order(r_k);
    assign from      = (r_k < 3'd3) ? i_cmd.phase : i_cmd.phase + 2'd2;
    assign pa        = key_pose(leg, t_pose_id'(from), i_cfg, 8'(MID_REACH_EXTRA));
    assign pb        = key_pose(leg, t_pose_id'(from + 2'd1), i_cfg, 8'(MID_REACH_EXTRA));
    assign prog_s    = $signed({1'b0, r_s1_prog});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_slots  <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_k <= (r_k == 3'(LEGS - 1)) ? '0 : r_k + 1'b1;
            end
            r_slots  <= r_slots + SW'(issue) - SW'(i_res_pop);
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_leg  <= leg;
        r_s1_last <= (r_k == 3'(LEGS - 1));
        r_s1_prog <= i_cmd.prog;
        r_s1_a    <= pa;
        r_s1_d.x  <= pb.x - pa.x;
        r_s1_d.y  <= pb.y - pa.y;
        r_s1_d.z  <= pb.z - pa.z;

        r_s2_leg  <= r_s1_leg;
        r_s2_last <= r_s1_last;
        r_s2_a    <= r_s1_a;
        r_s2_px   <= r_s1_d.x * prog_s;
        r_s2_py   <= r_s1_d.y * prog_s;
        r_s2_pz   <= r_s1_d.z * prog_s;
    end

    // arithmetic shift floors negative products
    assign sum_x = 16'(r_s2_a.x) + r_s2_px[23:8];
    assign sum_y = 16'(r_s2_a.y) + r_s2_py[23:8];
    assign sum_z = 16'(r_s2_a.z) + r_s2_pz[23:8];

    assign o_res_vld  = r_s2_vld;
    assign o_res.leg  = r_s2_leg;
    assign o_res.x    = sum_x[12:0];
    assign o_res.y    = sum_y[12:0];
    assign o_res.z    = sum_z[12:0];
    assign o_res.last = r_s2_last;

    a_slots_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots <= SW'(RES_DEPTH))
        else $error("result slots overcommitted");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != '0 |-> i_cmd_valid)
        else $error("command left queue mid sequence");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k < 3'(LEGS))
        else $error("leg counter out of range");

    a_last_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && r_s2_last |-> r_s2_leg == 3'd5)
        else $error("last word on wrong leg");

endmodule

[rtl/tgi_resq.sv]
// Result queue: holds finished leg target words until the consumer pops them.
// Uses tgi_pkg.
module tgi_resq import tgi_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_data,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_res          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_wr) - CW'(pop);
        end
    end

endmodule

[rtl/tripod_gait_interpolator.sv]
// Tripod gait interpolator top: configuration registers, front, back, result queue.
// A progress word passes the command queue, the back end's s1 and s2 registers
// and the result queue before its first leg target shows. Throughput: one leg
// target per cycle, set by back end leg issue; bounded by result queue space.
// Reset: synchronous active low; clears queues and phase, loads register defaults.
module tripod_gait_interpolator import tgi_pkg::*; #(
    parameter int CMD_DEPTH       = 4,
    parameter int RES_DEPTH       = 8,
    parameter int MID_REACH_EXTRA = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [8:0]        i_progress,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [2:0]        o_leg_index,
    output logic signed [12:0] o_foot_x,
    output logic signed [12:0] o_foot_y,
    output logic signed [12:0] o_foot_z,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [9:0]        i_cfg_wdata
);

    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_vld;
    t_res res;
    t_res head;
    logic res_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_step <= '0;
            r_cfg.side_step    <= '0;
            r_cfg.body_height  <= 10'd200;
            r_cfg.lift_height  <= 9'd100;
            r_cfg.leg_reach    <= 10'd100;
            r_cfg.leg_spacing  <= 10'd100;
            r_cfg.front_tilt   <= '0;
            r_cfg.side_tilt    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FORWARD_STEP: r_cfg.forward_step <= $signed(i_cfg_wdata[8:0]);
                REG_SIDE_STEP:    r_cfg.side_step    <= $signed(i_cfg_wdata[8:0]);
                REG_BODY_HEIGHT:  r_cfg.body_height  <= i_cfg_wdata;
                REG_LIFT_HEIGHT:  r_cfg.lift_height  <= i_cfg_wdata[8:0];
                REG_LEG_REACH:    r_cfg.leg_reach    <= i_cfg_wdata;
                REG_LEG_SPACING:  r_cfg.leg_spacing  <= i_cfg_wdata;
                REG_FRONT_TILT:   r_cfg.front_tilt   <= $signed(i_cfg_wdata[8:0]);
                REG_SIDE_TILT:    r_cfg.side_tilt    <= $signed(i_cfg_wdata[8:0]);
                default: begin
                end
            endcase
        end
    end

    tgi_front #(.CMD_DEPTH(CMD_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_progress  (i_progress),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tgi_back #(.RES_DEPTH(RES_DEPTH), .MID_REACH_EXTRA(MID_REACH_EXTRA)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_pop   (res_pop),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    assign res_pop = i_pop && !o_empty;

    tgi_resq #(.DEPTH(RES_DEPTH)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_vld),
        .i_data  (res),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (head)
    );

    assign o_leg_index = head.leg;
    assign o_foot_x    = head.x;
    assign o_foot_y    = head.y;
    assign o_foot_z    = head.z;
    assign o_last      = head.last;

endmodule
